FILE: hw/rtl/tps_pkg.sv
package tps_pkg;

    localparam int DIMENSION = 1023;
    localparam int COORD_W   = $clog2(DIMENSION + 1);
    localparam int PIX_W     = 10;
    localparam int VAL_W     = (COORD_W > PIX_W) ? COORD_W : PIX_W;
    localparam int EW        = 2 * VAL_W + 6;
    localparam int AREA_W    = 2 * VAL_W + 1;
    localparam int CH_W      = 8;
    localparam int NUM_W     = AREA_W + CH_W + 2;
    localparam int POS_W     = 32;
    localparam int COL_W     = 24;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 32;
    localparam int FRONT_LAT = 7;
    localparam int PIX_DLY   = 5;
    localparam int BACK_LAT  = 11;
    localparam int DIV_STEPS = CH_W;
    localparam int QDEPTH    = 16;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int OCC_W     = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_POS = 3'd0,
        REG_A_COL = 3'd1,
        REG_B_POS = 3'd2,
        REG_B_COL = 3'd3,
        REG_C_POS = 3'd4,
        REG_C_COL = 3'd5
    } cfg_reg_t;

    // derived triangle setup; the user keeps it stable while pixels flow, the block does not enforce this
    typedef struct packed {
        logic [2:0][COORD_W-1:0] x;
        logic [2:0][COORD_W-1:0] y;
        logic [2:0][EW-1:0]      a;
        logic [2:0][EW-1:0]      b;
        logic [2:0][EW-1:0]      c;
        logic [AREA_W-1:0]       total;
        logic                    zero;
        logic [2:0][COL_W-1:0]   col;
    } setup_t;

    typedef struct packed {
        logic              covered;
        logic [AREA_W-1:0] sa;
        logic [AREA_W-1:0] sb;
        logic [AREA_W-1:0] sc;
    } frag_t;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [15:0] f);
        logic [COORD_W-1:0] r;
        if (f[15])
        begin
            r = '0;
        end
        else if (f > 16'(DIMENSION))
        begin
            r = COORD_W'(DIMENSION);
        end
        else
        begin
            r = f[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/tps_setup.sv
module tps_setup import tps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data,
    output setup_t               setup
);

    logic [POS_W-1:0]   pos_reg [0:2];
    logic [COL_W-1:0]   col_reg [0:2];
    logic [COORD_W-1:0] x_reg   [0:2];
    logic [COORD_W-1:0] y_reg   [0:2];
    logic signed [EW-1:0] m1_reg, m2_reg;
    logic [AREA_W-1:0]  total3_reg, total4_reg;
    logic               zero4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                col_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_idx))
                REG_A_POS: pos_reg[0] <= cfg_data[POS_W-1:0];
                REG_A_COL: col_reg[0] <= cfg_data[COL_W-1:0];
                REG_B_POS: pos_reg[1] <= cfg_data[POS_W-1:0];
                REG_B_COL: col_reg[1] <= cfg_data[COL_W-1:0];
                REG_C_POS: pos_reg[2] <= cfg_data[POS_W-1:0];
                REG_C_COL: col_reg[2] <= cfg_data[COL_W-1:0];
                default: ;
            endcase
        end
    end

    // level 1: clamped vertices
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            x_reg[i] <= clamp_coord(pos_reg[i][15:0]);
            y_reg[i] <= clamp_coord(pos_reg[i][31:16]);
        end
    end

    // twice area of the whole triangle
    always_ff @(posedge clk)
    begin
        logic signed [EW-1:0] v;
        m1_reg <= (EW'(y_reg[1]) - EW'(y_reg[2])) * (EW'(x_reg[0]) - EW'(x_reg[2]));
        m2_reg <= (EW'(x_reg[1]) - EW'(x_reg[2])) * (EW'(y_reg[0]) - EW'(y_reg[2]));
        v = m1_reg - m2_reg;
        total3_reg <= v[EW-1] ? AREA_W'(-v) : AREA_W'(v);
        total4_reg <= total3_reg;
        zero4_reg  <= (total3_reg == '0);
    end

    for (genvar e = 0; e < 3; e++)
    begin : g_edge
        localparam int I0 = (e == 2) ? 1 : 0;
        localparam int I1 = (e == 0) ? 1 : 2;
        localparam int IO = 2 - e;

        logic signed [EW-1:0] a2_reg, b2_reg, pa2_reg, pb2_reg;
        logic signed [EW-1:0] a3_reg, b3_reg, c3_reg, oa3_reg, ob3_reg;
        logic signed [EW-1:0] a4_reg, b4_reg, c4_reg;
        logic signed [EW-1:0] a5_reg, b5_reg, c5_reg;
        logic                 flip4_reg;
        logic signed [EW-1:0] x0, y0, x1, y1, xo, yo, a_now, b_now, s, half, side;

        always_comb
        begin
            x0    = EW'(x_reg[I0]);
            y0    = EW'(y_reg[I0]);
            x1    = EW'(x_reg[I1]);
            y1    = EW'(y_reg[I1]);
            xo    = EW'(x_reg[IO]);
            yo    = EW'(y_reg[IO]);
            a_now = y0 - y1;
            b_now = x1 - x0;
            s     = pa2_reg + pb2_reg;
            // halve, truncating toward zero
            half  = (s + $signed({{(EW-1){1'b0}}, s[EW-1]})) >>> 1;
            side  = oa3_reg + ob3_reg + c3_reg;
        end

        always_ff @(posedge clk)
        begin
            a2_reg    <= a_now;
            b2_reg    <= b_now;
            pa2_reg   <= a_now * (x0 + x1);
            pb2_reg   <= b_now * (y0 + y1);
            a3_reg    <= a2_reg;
            b3_reg    <= b2_reg;
            c3_reg    <= -half;
            oa3_reg   <= a2_reg * xo;
            ob3_reg   <= b2_reg * yo;
            a4_reg    <= a3_reg;
            b4_reg    <= b3_reg;
            c4_reg    <= c3_reg;
            flip4_reg <= side[EW-1];
            a5_reg    <= flip4_reg ? -a4_reg : a4_reg;
            b5_reg    <= flip4_reg ? -b4_reg : b4_reg;
            c5_reg    <= flip4_reg ? -c4_reg : c4_reg;
        end

        assign setup.a[e] = a5_reg;
        assign setup.b[e] = b5_reg;
        assign setup.c[e] = c5_reg;
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_out
        assign setup.x[i]   = x_reg[i];
        assign setup.y[i]   = y_reg[i];
        assign setup.col[i] = col_reg[i];
    end

    assign setup.total = total4_reg;
    assign setup.zero  = zero4_reg;

endmodule

FILE: hw/rtl/tps_front.sv
module tps_front import tps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [PIX_W-1:0] px,
    input  logic [PIX_W-1:0] py,
    input  setup_t           setup,
    output logic             push,
    output frag_t            frag
);

    logic [FRONT_LAT-1:0] vld_reg, vld_next;
    logic [PIX_W-1:0]     px_reg [0:PIX_DLY-1];
    logic [PIX_W-1:0]     py_reg [0:PIX_DLY-1];
    logic signed [EW-1:0] ex_reg [0:2];
    logic signed [EW-1:0] ey_reg [0:2];
    logic signed [EW-1:0] p1_reg [0:2];
    logic signed [EW-1:0] p2_reg [0:2];
    frag_t                frag_reg, frag_next;
    logic signed [EW-1:0] ex_next [0:2];
    logic signed [EW-1:0] ey_next [0:2];
    logic signed [EW-1:0] p1_next [0:2];
    logic signed [EW-1:0] p2_next [0:2];

    assign vld_next = {vld_reg[FRONT_LAT-2:0], in_fire};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // edge products and sub-triangle cross products
    always_comb
    begin
        logic signed [EW-1:0] pxe, pye, dx0, dy0, dx1, dy1;
        int v0, v1;
        pxe = EW'(px_reg[PIX_DLY-1]);
        pye = EW'(py_reg[PIX_DLY-1]);
        for (int k = 0; k < 3; k++)
        begin
            v0 = (k + 1) % 3;
            v1 = (k + 2) % 3;
            ex_next[k] = $signed(setup.a[k]) * pxe;
            ey_next[k] = $signed(setup.b[k]) * pye;
            dx0 = EW'(setup.x[v0]) - pxe;
            dy0 = EW'(setup.y[v0]) - pye;
            dx1 = EW'(setup.x[v1]) - pxe;
            dy1 = EW'(setup.y[v1]) - pye;
            p1_next[k] = dy1 * dx0;
            p2_next[k] = dx1 * dy0;
        end
    end

    always_comb
    begin
        logic signed [EW-1:0] es, v;
        logic                 hit;
        logic [AREA_W-1:0]    area [0:2];
        hit = !setup.zero;
        for (int k = 0; k < 3; k++)
        begin
            es      = ex_reg[k] + ey_reg[k] + $signed(setup.c[k]);
            hit     = hit & !es[EW-1];
            v       = p1_reg[k] - p2_reg[k];
            area[k] = v[EW-1] ? AREA_W'(-v) : AREA_W'(v);
        end
        frag_next.covered = hit;
        frag_next.sa      = area[0];
        frag_next.sb      = area[1];
        frag_next.sc      = area[2];
    end

    always_ff @(posedge clk)
    begin
        px_reg[0] <= px;
        py_reg[0] <= py;
        for (int i = 1; i < PIX_DLY; i++)
        begin
            px_reg[i] <= px_reg[i-1];
            py_reg[i] <= py_reg[i-1];
        end
        for (int k = 0; k < 3; k++)
        begin
            ex_reg[k] <= ex_next[k];
            ey_reg[k] <= ey_next[k];
            p1_reg[k] <= p1_next[k];
            p2_reg[k] <= p2_next[k];
        end
        frag_reg <= frag_next;
    end

    assign push = vld_reg[FRONT_LAT-1];
    assign frag = frag_reg;

endmodule

FILE: hw/rtl/tps_queue.sv
module tps_queue import tps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  frag_t din,
    input  logic  pop,
    output logic  not_empty,
    output frag_t dout
);

    frag_t             mem_reg [0:QDEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OCC_W-1:0]  cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        cnt_next    = cnt_reg + OCC_W'(push) - OCC_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign not_empty = (cnt_reg != '0);
    assign dout      = mem_reg[rd_ptr_reg];

endmodule

FILE: hw/rtl/tps_back.sv
module tps_back import tps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  frag_t            q_frag,
    input  setup_t           setup,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    localparam int PR_W = AREA_W + CH_W;

    logic [BACK_LAT-1:0] v_reg, v_next;
    logic [BACK_LAT-1:0] cov_reg, cov_next;
    logic                adv;

    logic [PR_W-1:0]  prod_reg [0:2][0:2];
    logic [PR_W-1:0]  prod_next [0:2][0:2];
    logic [NUM_W-1:0] num_reg [0:2];
    logic [NUM_W-1:0] num_next [0:2];
    logic [NUM_W-1:0] rem_reg [0:DIV_STEPS][0:2];
    logic [NUM_W-1:0] rem_next [0:DIV_STEPS][0:2];
    logic [CH_W-1:0]  q_reg [0:DIV_STEPS][0:2];
    logic [CH_W-1:0]  q_next [0:DIV_STEPS][0:2];
    logic             sat_reg [0:DIV_STEPS][0:2];
    logic             sat_next [0:DIV_STEPS][0:2];
    logic [CH_W-1:0]  chan [0:2];

    // whole pipe moves together; the last stage is the output register
    assign adv      = !v_reg[BACK_LAT-1] || m_tready;
    assign pop      = adv && q_valid;
    assign v_next   = adv ? {v_reg[BACK_LAT-2:0], q_valid} : v_reg;
    assign cov_next = {cov_reg[BACK_LAT-2:0], q_frag.covered};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_comb
    begin
        logic [AREA_W-1:0] s [0:2];
        logic [NUM_W-1:0]  sh;
        s[0] = q_frag.sa;
        s[1] = q_frag.sb;
        s[2] = q_frag.sc;
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int v = 0; v < 3; v++)
            begin
                prod_next[ch][v] = PR_W'(s[v]) * PR_W'(setup.col[v][COL_W-1-CH_W*ch -: CH_W]);
            end
            num_next[ch] = NUM_W'(prod_reg[ch][0]) + NUM_W'(prod_reg[ch][1])
                         + NUM_W'(prod_reg[ch][2]);
            // quotient of 256 or more saturates
            rem_next[0][ch] = num_reg[ch];
            q_next[0][ch]   = '0;
            sat_next[0][ch] = (num_reg[ch] >= (NUM_W'(setup.total) << CH_W));
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                sh = NUM_W'(setup.total) << (DIV_STEPS - 1 - j);
                rem_next[j+1][ch] = rem_reg[j][ch];
                q_next[j+1][ch]   = q_reg[j][ch];
                sat_next[j+1][ch] = sat_reg[j][ch];
                if (rem_reg[j][ch] >= sh)
                begin
                    rem_next[j+1][ch] = rem_reg[j][ch] - sh;
                    q_next[j+1][ch][DIV_STEPS-1-j] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cov_reg <= cov_next;
            for (int ch = 0; ch < 3; ch++)
            begin
                for (int v = 0; v < 3; v++)
                begin
                    prod_reg[ch][v] <= prod_next[ch][v];
                end
                num_reg[ch] <= num_next[ch];
                for (int j = 0; j <= DIV_STEPS; j++)
                begin
                    rem_reg[j][ch] <= rem_next[j][ch];
                    q_reg[j][ch]   <= q_next[j][ch];
                    sat_reg[j][ch] <= sat_next[j][ch];
                end
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            if (!cov_reg[BACK_LAT-1])
            begin
                chan[ch] = '0;
            end
            else if (sat_reg[DIV_STEPS][ch])
            begin
                chan[ch] = '1;
            end
            else
            begin
                chan[ch] = q_reg[DIV_STEPS][ch];
            end
        end
    end

    assign m_tvalid = v_reg[BACK_LAT-1];
    assign m_tdata  = {{(OUT_W - 1 - 3 * CH_W){1'b0}}, chan[2], chan[1], chan[0],
                       cov_reg[BACK_LAT-1]};

endmodule

FILE: hw/rtl/triangle_pixel_shader.sv
// triangle pixel shader: coverage test and gouraud colour for one pixel per beat
//
// s_* channel: one pixel coordinate per beat. m_* channel: one result beat
// per pixel, in order. cfg_* port: write vertex positions and colours while
// the block is idle (indexes 0..5, larger indexes are ignored).
//
// the result path runs through 7 front stages, the queue and 11 back stages;
// the back stages hold while the output is stalled.
// throughput: one pixel per cycle while the output is not stalled; the front
// edge/area multipliers and the back channel multipliers and 8-stage restoring
// divider are all pipelined. triangle setup after a register write settles
// through the tps_setup clamp and edge registers, covered by the front stages.
//
// reset clears the config, valid, pointer and count registers, emptying the pipe.
// when m_tready is low with a result waiting the back pipe holds; the front keeps taking pixels
// until 16 are in flight between the input and the back pipe, then
// s_tready drops.
module triangle_pixel_shader import tps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // pixel_x, pixel_y
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,   // covered, red_out, green_out, blue_out
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data
);

    setup_t           setup;
    logic             fire, push, pop, q_valid;
    frag_t            push_frag, q_frag;
    logic [OCC_W-1:0] occ_reg, occ_next;

    // beats accepted but not yet taken by the back pipe
    assign s_tready = (occ_reg < OCC_W'(QDEPTH));
    assign fire     = s_tvalid && s_tready;
    assign occ_next = occ_reg + OCC_W'(fire) - OCC_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    tps_setup u_setup
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .setup    (setup)
    );

    tps_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (fire),
        .px      (s_tdata[PIX_W-1:0]),
        .py      (s_tdata[2*PIX_W-1:PIX_W]),
        .setup   (setup),
        .push    (push),
        .frag    (push_frag)
    );

    tps_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (push_frag),
        .pop       (pop),
        .not_empty (q_valid),
        .dout      (q_frag)
    );

    tps_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_frag   (q_frag),
        .setup    (setup),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: hw/rtl/tps_checker.sv
module tps_checker import tps_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // uncovered pixels carry black
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[3*CH_W:1] == '0)
        else $error("uncovered pixel with nonzero colour");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_W-1:3*CH_W+1] == '0)
        else $error("padding bits set in result beat");

endmodule

bind triangle_pixel_shader tps_checker u_tps_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
